>>> src/wfs_pkg.sv
// Shared types, constants and codes for the windowed frame statistics block.
package wfs_pkg;

    localparam int COUNT_WIDTH = 12;
    localparam int SUM_WIDTH   = 44;
    localparam int FLUSH_SUM_W = 28;
    localparam int TIME_W      = 32;
    localparam int DVR_W       = 32;

    localparam int FPS_SCALE   = 10000;
    localparam int FPS_SCALE_W = 14;
    localparam int FPS_MUL_W   = COUNT_WIDTH + FPS_SCALE_W;
    localparam int FLUSH_MUL_W = FLUSH_SUM_W + 4;

    localparam int DIV_W_A = SUM_WIDTH + 1;
    localparam int DIV_W_B = (FPS_MUL_W > FLUSH_MUL_W + 1) ? FPS_MUL_W : FLUSH_MUL_W + 1;
    localparam int DIV_W   = (DIV_W_A > DIV_W_B) ? DIV_W_A : DIV_W_B;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int WIN_LEN_W  = 16;
    localparam int LIMIT_W    = 12;

    localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET     = 16'd1000;
    localparam logic [LIMIT_W-1:0]   FRAME_LIMIT_RESET = 12'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEN     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 1'd1;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_TICK    = 2'd0;
    localparam t_kind KIND_FRAME   = 2'd1;
    localparam t_kind KIND_RESTART = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_CHECK,
        ST_LOAD,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        OP_FPS,
        OP_MEAN_FRAME,
        OP_MEAN_RENDER,
        OP_MEAN_WAIT,
        OP_MEAN_PIXELS,
        OP_FLUSH
    } t_div_op;

    typedef struct packed {
        t_kind        kind;
        logic [31:0]  now_ms;
        logic [31:0]  frame_time_us;
        logic [31:0]  render_time_us;
        logic [31:0]  wait_time_us;
        logic [31:0]  pixel_count;
        logic [15:0]  flush_count;
    } t_in_item;

    typedef struct packed {
        logic         stats_valid;
        logic [31:0]  age_ms;
        logic [31:0]  elapsed_ms;
        logic [11:0]  frames_seen;
        logic [25:0]  fps_tenths;
        logic [31:0]  mean_frame_us;
        logic [31:0]  max_frame_us;
        logic [31:0]  mean_render_us;
        logic [31:0]  mean_wait_us;
        logic [31:0]  mean_pixels;
        logic [19:0]  flushes_per_frame_tenths;
    } t_out_item;

endpackage

>>> src/wfs_if.sv
// Valid/ready stream interfaces for the input and result channels.
interface wfs_in_if;
    import wfs_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface wfs_out_if;
    import wfs_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/windowed_frame_stats.sv
// Windowed frame statistics: window sums, close logic and a shared iterative divider.
// Ticks and frames pass ST_ACC then ST_CHECK; other kinds go from ST_ACC to ST_EMIT.
// A closing window with frames runs six divisions through one radix-2 divider,
// one at a time, each loaded in ST_LOAD and iterated in ST_DIV.
// One beat is processed at a time; the next is accepted once the result is registered.
// Sync, active-low reset restores defaults; item, divider, output data are not reset.
module windowed_frame_stats (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    wfs_in_if.sink                         i_in,
    wfs_out_if.source                      o_out
);
    import wfs_pkg::*;

    t_state                 r_state, n_state;
    t_div_op                r_op, n_op;
    t_in_item               r_item, n_item;
    logic [WIN_LEN_W-1:0]   r_win_len, n_win_len;
    logic [LIMIT_W-1:0]     r_frame_limit, n_frame_limit;
    logic [TIME_W-1:0]      r_win_start, n_win_start;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [SUM_WIDTH-1:0]   r_frame_sum, n_frame_sum;
    logic [SUM_WIDTH-1:0]   r_render_sum, n_render_sum;
    logic [SUM_WIDTH-1:0]   r_wait_sum, n_wait_sum;
    logic [SUM_WIDTH-1:0]   r_pixel_sum, n_pixel_sum;
    logic [FLUSH_SUM_W-1:0] r_flush_sum, n_flush_sum;
    logic [31:0]            r_peak, n_peak;

    logic                   r_pub_valid, n_pub_valid;
    logic [TIME_W-1:0]      r_pub_at, n_pub_at;
    logic [31:0]            r_pub_elapsed, n_pub_elapsed;
    logic [11:0]            r_pub_frames, n_pub_frames;
    logic [25:0]            r_pub_fps, n_pub_fps;
    logic [31:0]            r_pub_mean_frame, n_pub_mean_frame;
    logic [31:0]            r_pub_max, n_pub_max;
    logic [31:0]            r_pub_mean_render, n_pub_mean_render;
    logic [31:0]            r_pub_mean_wait, n_pub_mean_wait;
    logic [31:0]            r_pub_mean_pixels, n_pub_mean_pixels;
    logic [19:0]            r_pub_flush, n_pub_flush;

    logic [DIV_W-1:0]       r_div_q, n_div_q;
    logic [DVR_W-1:0]       r_div_rem, n_div_rem;
    logic [DVR_W-1:0]       r_div_d, n_div_d;
    logic [DIV_CNT_W-1:0]   r_div_cnt, n_div_cnt;

    logic                   r_out_valid, n_out_valid;
    t_out_item              r_out_data, n_out_data;

    logic [TIME_W-1:0]      since;
    logic                   time_up;
    logic                   count_hit;
    logic [31:0]            span;
    logic [FPS_MUL_W-1:0]   fps_prod;
    logic [FLUSH_MUL_W-1:0] flush_x10;
    logic [DIV_W-1:0]       half_n;
    logic [DIV_W-1:0]       dividend;
    logic [DVR_W-1:0]       divisor;
    logic [DVR_W:0]         trial;
    logic [DVR_W:0]         trial_diff;
    logic                   trial_ge;
    logic                   div_last;
    logic                   out_free;
    logic                   open_win;

    assign since     = r_item.now_ms - r_win_start;
    assign time_up   = since >= TIME_W'(r_win_len);
    assign count_hit = 32'(r_count) >= 32'(r_frame_limit);
    assign span      = (since == '0) ? 32'd1 : since;
    assign fps_prod  = FPS_MUL_W'(r_count) * FPS_MUL_W'(FPS_SCALE);
    assign flush_x10 = (FLUSH_MUL_W'(r_flush_sum) << 3) + (FLUSH_MUL_W'(r_flush_sum) << 1);
    assign half_n    = DIV_W'(r_count >> 1);

    always_comb begin
        case (r_op)
            OP_FPS:         dividend = DIV_W'(fps_prod);
            OP_MEAN_FRAME:  dividend = DIV_W'(r_frame_sum) + half_n;
            OP_MEAN_RENDER: dividend = DIV_W'(r_render_sum) + half_n;
            OP_MEAN_WAIT:   dividend = DIV_W'(r_wait_sum) + half_n;
            OP_MEAN_PIXELS: dividend = DIV_W'(r_pixel_sum) + half_n;
            OP_FLUSH:       dividend = DIV_W'(flush_x10) + half_n;
            default:        dividend = '0;
        endcase
        divisor = (r_op == OP_FPS) ? r_pub_elapsed : DVR_W'(r_count);
    end

    assign trial      = {r_div_rem, r_div_q[DIV_W-1]};
    assign trial_diff = trial - {1'b0, r_div_d};
    assign trial_ge   = trial >= {1'b0, r_div_d};
    assign div_last   = r_div_cnt == DIV_CNT_W'(DIV_W - 1);
    assign out_free   = !r_out_valid || o_out.ready;

    always_comb begin
        n_state           = r_state;
        n_op              = r_op;
        n_item            = r_item;
        n_win_len         = r_win_len;
        n_frame_limit     = r_frame_limit;
        n_win_start       = r_win_start;
        n_count           = r_count;
        n_frame_sum       = r_frame_sum;
        n_render_sum      = r_render_sum;
        n_wait_sum        = r_wait_sum;
        n_pixel_sum       = r_pixel_sum;
        n_flush_sum       = r_flush_sum;
        n_peak            = r_peak;
        n_pub_valid       = r_pub_valid;
        n_pub_at          = r_pub_at;
        n_pub_elapsed     = r_pub_elapsed;
        n_pub_frames      = r_pub_frames;
        n_pub_fps         = r_pub_fps;
        n_pub_mean_frame  = r_pub_mean_frame;
        n_pub_max         = r_pub_max;
        n_pub_mean_render = r_pub_mean_render;
        n_pub_mean_wait   = r_pub_mean_wait;
        n_pub_mean_pixels = r_pub_mean_pixels;
        n_pub_flush       = r_pub_flush;
        n_div_q           = r_div_q;
        n_div_rem         = r_div_rem;
        n_div_d           = r_div_d;
        n_div_cnt         = r_div_cnt;
        n_out_valid       = r_out_valid && !o_out.ready;
        n_out_data        = r_out_data;
        open_win          = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIN_LEN:     n_win_len = i_cfg_data[WIN_LEN_W-1:0];
                CFG_FRAME_LIMIT: n_frame_limit = i_cfg_data[LIMIT_W-1:0];
                default:         n_win_len = r_win_len;
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_item  = i_in.data;
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                case (r_item.kind)
                    KIND_TICK: begin
                        n_state = ST_CHECK;
                    end
                    KIND_FRAME: begin
                        n_count      = r_count + 1'b1;
                        n_frame_sum  = r_frame_sum + SUM_WIDTH'(r_item.frame_time_us);
                        n_render_sum = r_render_sum + SUM_WIDTH'(r_item.render_time_us);
                        n_wait_sum   = r_wait_sum + SUM_WIDTH'(r_item.wait_time_us);
                        n_pixel_sum  = r_pixel_sum + SUM_WIDTH'(r_item.pixel_count);
                        n_flush_sum  = r_flush_sum + FLUSH_SUM_W'(r_item.flush_count);
                        if (r_item.frame_time_us > r_peak) begin
                            n_peak = r_item.frame_time_us;
                        end
                        n_state = ST_CHECK;
                    end
                    KIND_RESTART: begin
                        n_pub_valid       = 1'b0;
                        n_pub_at          = r_item.now_ms;
                        n_pub_elapsed     = '0;
                        n_pub_frames      = '0;
                        n_pub_fps         = '0;
                        n_pub_mean_frame  = '0;
                        n_pub_max         = '0;
                        n_pub_mean_render = '0;
                        n_pub_mean_wait   = '0;
                        n_pub_mean_pixels = '0;
                        n_pub_flush       = '0;
                        open_win          = 1'b1;
                        n_state           = ST_EMIT;
                    end
                    default: begin
                        n_state = ST_EMIT;
                    end
                endcase
            end
            ST_CHECK: begin
                if (time_up || (r_item.kind == KIND_FRAME && count_hit)) begin
                    if (r_count != '0) begin
                        n_pub_valid   = 1'b1;
                        n_pub_at      = r_item.now_ms;
                        n_pub_elapsed = span;
                        n_pub_frames  = 12'(r_count);
                        n_pub_max     = r_peak;
                        n_op          = OP_FPS;
                        n_state       = ST_LOAD;
                    end else begin
                        open_win = 1'b1;
                        n_state  = ST_EMIT;
                    end
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_LOAD: begin
                n_div_q   = dividend;
                n_div_rem = '0;
                n_div_d   = divisor;
                n_div_cnt = '0;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                n_div_rem = trial_ge ? trial_diff[DVR_W-1:0] : trial[DVR_W-1:0];
                n_div_q   = {r_div_q[DIV_W-2:0], trial_ge};
                n_div_cnt = r_div_cnt + 1'b1;
                if (div_last) begin
                    n_state = ST_LOAD;
                    case (r_op)
                        OP_FPS: begin
                            n_pub_fps = n_div_q[25:0];
                            n_op      = OP_MEAN_FRAME;
                        end
                        OP_MEAN_FRAME: begin
                            n_pub_mean_frame = n_div_q[31:0];
                            n_op             = OP_MEAN_RENDER;
                        end
                        OP_MEAN_RENDER: begin
                            n_pub_mean_render = n_div_q[31:0];
                            n_op              = OP_MEAN_WAIT;
                        end
                        OP_MEAN_WAIT: begin
                            n_pub_mean_wait = n_div_q[31:0];
                            n_op            = OP_MEAN_PIXELS;
                        end
                        OP_MEAN_PIXELS: begin
                            n_pub_mean_pixels = n_div_q[31:0];
                            n_op              = OP_FLUSH;
                        end
                        default: begin
                            n_pub_flush = n_div_q[19:0];
                            open_win    = 1'b1;
                            n_state     = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid                         = 1'b1;
                    n_out_data.stats_valid              = r_pub_valid;
                    n_out_data.age_ms                   = r_pub_valid ?
                                                          (r_item.now_ms - r_pub_at) : '0;
                    n_out_data.elapsed_ms               = r_pub_elapsed;
                    n_out_data.frames_seen              = r_pub_frames;
                    n_out_data.fps_tenths               = r_pub_fps;
                    n_out_data.mean_frame_us            = r_pub_mean_frame;
                    n_out_data.max_frame_us             = r_pub_max;
                    n_out_data.mean_render_us           = r_pub_mean_render;
                    n_out_data.mean_wait_us             = r_pub_mean_wait;
                    n_out_data.mean_pixels              = r_pub_mean_pixels;
                    n_out_data.flushes_per_frame_tenths = r_pub_flush;
                    n_state                             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (open_win) begin
            n_win_start  = r_item.now_ms;
            n_count      = '0;
            n_frame_sum  = '0;
            n_render_sum = '0;
            n_wait_sum   = '0;
            n_pixel_sum  = '0;
            n_flush_sum  = '0;
            n_peak       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_op              <= OP_FPS;
            r_win_len         <= WIN_LEN_RESET;
            r_frame_limit     <= FRAME_LIMIT_RESET;
            r_win_start       <= '0;
            r_count           <= '0;
            r_frame_sum       <= '0;
            r_render_sum      <= '0;
            r_wait_sum        <= '0;
            r_pixel_sum       <= '0;
            r_flush_sum       <= '0;
            r_peak            <= '0;
            r_pub_valid       <= 1'b0;
            r_pub_at          <= '0;
            r_pub_elapsed     <= '0;
            r_pub_frames      <= '0;
            r_pub_fps         <= '0;
            r_pub_mean_frame  <= '0;
            r_pub_max         <= '0;
            r_pub_mean_render <= '0;
            r_pub_mean_wait   <= '0;
            r_pub_mean_pixels <= '0;
            r_pub_flush       <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            r_state           <= n_state;
            r_op              <= n_op;
            r_win_len         <= n_win_len;
            r_frame_limit     <= n_frame_limit;
            r_win_start       <= n_win_start;
            r_count           <= n_count;
            r_frame_sum       <= n_frame_sum;
            r_render_sum      <= n_render_sum;
            r_wait_sum        <= n_wait_sum;
            r_pixel_sum       <= n_pixel_sum;
            r_flush_sum       <= n_flush_sum;
            r_peak            <= n_peak;
            r_pub_valid       <= n_pub_valid;
            r_pub_at          <= n_pub_at;
            r_pub_elapsed     <= n_pub_elapsed;
            r_pub_frames      <= n_pub_frames;
            r_pub_fps         <= n_pub_fps;
            r_pub_mean_frame  <= n_pub_mean_frame;
            r_pub_max         <= n_pub_max;
            r_pub_mean_render <= n_pub_mean_render;
            r_pub_mean_wait   <= n_pub_mean_wait;
            r_pub_mean_pixels <= n_pub_mean_pixels;
            r_pub_flush       <= n_pub_flush;
            r_out_valid       <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_div_q    <= n_div_q;
        r_div_rem  <= n_div_rem;
        r_div_d    <= n_div_d;
        r_div_cnt  <= n_div_cnt;
        r_out_data <= n_out_data;
    end

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("Block stayed ready after accepting a beat.");

    a_divider_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_div_rem < r_div_d))
        else $error("Divider remainder is not below the divisor.");

    a_published_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pub_valid |-> (r_pub_elapsed != '0 && r_pub_frames != '0))
        else $error("Published window has zero length or no frames.");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data.stats_valid) |->
        (r_out_data.age_ms == '0 && r_out_data.elapsed_ms == '0 &&
         r_out_data.max_frame_us == '0))
        else $error("Result without published stats carries nonzero fields.");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the windowed frame statistics block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wfs_pkg::*;

    localparam t_kind       KIND_UNUSED    = 2'd3;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES   = 50;

    localparam t_out_item NO_STATS = '0;
    localparam t_out_item FIRST_SET = '{
        stats_valid: 1'b1, age_ms: 32'd0, elapsed_ms: 32'd1000, frames_seen: 12'd2,
        fps_tenths: 26'd20, mean_frame_us: 32'h8000_0000, max_frame_us: 32'hFFFF_FFFF,
        mean_render_us: 32'h8000_0000, mean_wait_us: 32'h8000_0000,
        mean_pixels: 32'h8000_0000, flushes_per_frame_tenths: 20'd327675};
    localparam t_out_item FIRST_SET_LATER = '{
        stats_valid: 1'b1, age_ms: 32'd500, elapsed_ms: 32'd1000, frames_seen: 12'd2,
        fps_tenths: 26'd20, mean_frame_us: 32'h8000_0000, max_frame_us: 32'hFFFF_FFFF,
        mean_render_us: 32'h8000_0000, mean_wait_us: 32'h8000_0000,
        mean_pixels: 32'h8000_0000, flushes_per_frame_tenths: 20'd327675};

    typedef logic [SUM_WIDTH-1:0]   t_sum;
    typedef logic [FLUSH_SUM_W-1:0] t_flush_sum;
    typedef enum {STEP_BEAT, STEP_REGISTER} t_step_op;

    typedef struct {
        t_step_op               op;
        t_in_item               beat;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_val;
        bit                     typed;
        t_out_item              want;
    } t_directed_step;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    wfs_in_if  in_ch ();
    wfs_out_if out_ch ();

    windowed_frame_stats DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always #2 clk = ~clk;

    logic [WIN_LEN_W-1:0] win_len     = WIN_LEN_RESET;
    logic [LIMIT_W-1:0]   frame_limit = FRAME_LIMIT_RESET;
    logic [31:0]          win_start   = '0;
    logic [COUNT_WIDTH-1:0] frame_cnt = '0;
    t_sum                 sum_frame   = '0;
    t_sum                 sum_render  = '0;
    t_sum                 sum_wait    = '0;
    t_sum                 sum_pixels  = '0;
    t_flush_sum           sum_flush   = '0;
    logic [31:0]          peak_frame  = '0;
    bit                   pub_ok      = 1'b0;
    t_out_item            published   = '0;
    logic [31:0]          pub_time    = '0;

    t_out_item      expected_stats[$];
    t_directed_step directed_steps[$];
    bit             failed = 1'b0;
    bit             src_on = 1'b0;
    int unsigned    burst_left;
    logic [31:0]    now_track;
    int unsigned    idle_cycles;
    int unsigned    ready_mode = 0;
    int unsigned    mode_left  = 0;

    function automatic logic [63:0] rounded_avg(logic [63:0] total, logic [63:0] n);
        return (total + (n >> 1)) / n;
    endfunction

    function automatic void open_window_at(logic [31:0] now);
        win_start  = now;
        frame_cnt  = '0;
        sum_frame  = '0;
        sum_render = '0;
        sum_wait   = '0;
        sum_pixels = '0;
        sum_flush  = '0;
        peak_frame = '0;
    endfunction

    function automatic void close_window_at(logic [31:0] now);
        logic [31:0] span;
        logic [63:0] n;
        logic [63:0] q;
        if (frame_cnt != '0) begin
            span = now - win_start;
            if (span == 32'd0) begin
                span = 32'd1;
            end
            n = 64'(frame_cnt);
            pub_ok = 1'b1;
            published.elapsed_ms  = span;
            published.frames_seen = frame_cnt;
            q = (n * 64'd10000) / 64'(span);
            published.fps_tenths = q[25:0];
            q = rounded_avg(64'(sum_frame), n);
            published.mean_frame_us = q[31:0];
            published.max_frame_us = peak_frame;
            q = rounded_avg(64'(sum_render), n);
            published.mean_render_us = q[31:0];
            q = rounded_avg(64'(sum_wait), n);
            published.mean_wait_us = q[31:0];
            q = rounded_avg(64'(sum_pixels), n);
            published.mean_pixels = q[31:0];
            q = rounded_avg(64'(sum_flush) * 64'd10, n);
            published.flushes_per_frame_tenths = q[19:0];
            pub_time = now;
        end
        open_window_at(now);
    endfunction

    function automatic t_out_item stats_after_beat(t_in_item it);
        t_out_item   r;
        logic [31:0] since;
        since = it.now_ms - win_start;
        case (it.kind)
            KIND_TICK: begin
                if (since >= {16'd0, win_len}) begin
                    close_window_at(it.now_ms);
                end
            end
            KIND_FRAME: begin
                frame_cnt  = frame_cnt + 1'b1;
                sum_frame  = sum_frame + t_sum'(it.frame_time_us);
                sum_render = sum_render + t_sum'(it.render_time_us);
                sum_wait   = sum_wait + t_sum'(it.wait_time_us);
                sum_pixels = sum_pixels + t_sum'(it.pixel_count);
                sum_flush  = sum_flush + t_flush_sum'(it.flush_count);
                if (it.frame_time_us > peak_frame) begin
                    peak_frame = it.frame_time_us;
                end
                if (frame_cnt >= frame_limit || since >= {16'd0, win_len}) begin
                    close_window_at(it.now_ms);
                end
            end
            KIND_RESTART: begin
                pub_ok    = 1'b0;
                published = '0;
                pub_time  = it.now_ms;
                open_window_at(it.now_ms);
            end
            default: begin
            end
        endcase
        r = '0;
        if (pub_ok) begin
            r = published;
            r.stats_valid = 1'b1;
            r.age_ms = it.now_ms - pub_time;
        end
        return r;
    endfunction

    function automatic logic [31:0] pick_word(int unsigned typical);
        case ($urandom_range(0, 9))
            0: return 32'hFFFF_FFFF;
            1: return 32'd0;
            2, 3: return $urandom();
            default: return $urandom_range(0, typical);
        endcase
    endfunction

    function automatic t_in_item random_beat();
        t_in_item    it;
        int unsigned pick;
        int unsigned hint;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            it.kind = KIND_FRAME;
        end else if (pick < 90) begin
            it.kind = KIND_TICK;
        end else if (pick < 96) begin
            it.kind = KIND_RESTART;
        end else begin
            it.kind = KIND_UNUSED;
        end
        hint = int'(win_len) / 4 + 1;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            now_track = now_track + $urandom_range(0, hint);
        end else if (pick < 88) begin
            now_track = now_track + {16'd0, win_len} + $urandom_range(0, 3);
        end else if (pick < 95) begin
            now_track = now_track;
        end else begin
            now_track = $urandom();
        end
        it.now_ms         = now_track;
        it.frame_time_us  = pick_word(40000);
        it.render_time_us = pick_word(25000);
        it.wait_time_us   = pick_word(15000);
        it.pixel_count    = pick_word(320 * 240);
        if ($urandom_range(0, 3) == 0) begin
            it.flush_count = 16'($urandom());
        end else begin
            it.flush_count = 16'($urandom_range(0, 6));
        end
        return it;
    endfunction

    function automatic void add_beat(t_kind k, logic [31:0] now, logic [31:0] ft,
                                     logic [31:0] rt, logic [31:0] wt, logic [31:0] px,
                                     logic [15:0] fl, bit typed, t_out_item want);
        t_directed_step s;
        s.op      = STEP_BEAT;
        s.beat    = '{kind: k, now_ms: now, frame_time_us: ft, render_time_us: rt,
                      wait_time_us: wt, pixel_count: px, flush_count: fl};
        s.reg_idx = '0;
        s.reg_val = '0;
        s.typed   = typed;
        s.want    = want;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_directed_step s;
        s.op      = STEP_REGISTER;
        s.beat    = '0;
        s.reg_idx = idx;
        s.reg_val = val;
        s.typed   = 1'b0;
        s.want    = '0;
        directed_steps.push_back(s);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
            failed = 1'b1;
        end
    endfunction

    task automatic go_idle();
        if (src_on) begin
            in_ch.valid <= 1'b0;
            src_on = 1'b0;
        end
    endtask

    task automatic hold_until_drained();
        go_idle();
        while (expected_stats.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        hold_until_drained();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_WIN_LEN) begin
            win_len = val[WIN_LEN_W-1:0];
        end else if (idx == CFG_FRAME_LIMIT) begin
            frame_limit = val[LIMIT_W-1:0];
        end
    endtask

    task automatic drive_beat(t_in_item it, bit typed, t_out_item want);
        t_out_item predicted;
        in_ch.data  <= it;
        in_ch.valid <= 1'b1;
        src_on = 1'b1;
        do begin
            @(posedge clk);
        end while (!in_ch.ready);
        predicted = stats_after_beat(it);
        expected_stats.push_back(typed ? want : predicted);
        if (burst_left > 0) begin
            burst_left--;
        end
        if (burst_left == 0) begin
            go_idle();
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if ($urandom_range(0, 9) == 0) begin
                burst_left = $urandom_range(50, 200);
            end else begin
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    task automatic run_phase(logic [CFG_DATA_W-1:0] len, logic [CFG_DATA_W-1:0] lim,
                             int unsigned beats);
        int unsigned k;
        set_register(CFG_WIN_LEN, len);
        set_register(CFG_FRAME_LIMIT, lim);
        for (k = 0; k < beats; k++) begin
            if (k == beats / 2) begin
                hold_until_drained();
            end
            drive_beat(random_beat(), 1'b0, NO_STATS);
        end
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_stats.size() == 0) begin
                    $display("%0t ns: result beat with no expectation waiting", $time);
                    failed = 1'b1;
                end else begin
                    want = expected_stats.pop_front();
                    check_field("stats_valid", 32'(want.stats_valid),
                                32'(out_ch.data.stats_valid));
                    check_field("age_ms", want.age_ms, out_ch.data.age_ms);
                    check_field("elapsed_ms", want.elapsed_ms, out_ch.data.elapsed_ms);
                    check_field("frames_seen", 32'(want.frames_seen),
                                32'(out_ch.data.frames_seen));
                    check_field("fps_tenths", 32'(want.fps_tenths),
                                32'(out_ch.data.fps_tenths));
                    check_field("mean_frame_us", want.mean_frame_us,
                                out_ch.data.mean_frame_us);
                    check_field("max_frame_us", want.max_frame_us, out_ch.data.max_frame_us);
                    check_field("mean_render_us", want.mean_render_us,
                                out_ch.data.mean_render_us);
                    check_field("mean_wait_us", want.mean_wait_us, out_ch.data.mean_wait_us);
                    check_field("mean_pixels", want.mean_pixels, out_ch.data.mean_pixels);
                    check_field("flushes_per_frame_tenths",
                                32'(want.flushes_per_frame_tenths),
                                32'(out_ch.data.flushes_per_frame_tenths));
                end
            end
            if (mode_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(32, 400);
            end else begin
                mode_left--;
            end
            case (ready_mode)
                0: out_ch.ready <= 1'b1;
                1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                default: out_ch.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t ns: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= '0;
        cfg_data     <= '0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        burst_left = $urandom_range(1, 12);
        now_track  = 32'd0;

        add_beat(KIND_TICK, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 1'b1, NO_STATS);
        add_beat(KIND_UNUSED, 32'd5, '1, '1, '1, '1, '1, 1'b1, NO_STATS);
        add_beat(KIND_FRAME, 32'd10, '1, '1, 32'd0, '1, 16'hFFFF, 1'b1, NO_STATS);
        add_beat(KIND_FRAME, 32'd20, 32'd0, 32'd0, '1, 32'd0, 16'd0, 1'b1, NO_STATS);
        add_beat(KIND_TICK, 32'd1000, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 1'b1, FIRST_SET);
        add_beat(KIND_TICK, 32'd1500, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 1'b1,
                 FIRST_SET_LATER);
        add_beat(KIND_RESTART, 32'd1600, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 1'b1, NO_STATS);
        add_beat(KIND_TICK, 32'd1700, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 1'b1, NO_STATS);
        add_setting(CFG_FRAME_LIMIT, 16'd0);
        add_beat(KIND_FRAME, 32'd1750, 32'd100, 32'd60, 32'd40, 32'd76800, 16'd3,
                 1'b0, NO_STATS);
        add_setting(CFG_WIN_LEN, 16'd0);
        add_beat(KIND_TICK, 32'd1750, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, NO_STATS);
        add_setting(CFG_FRAME_LIMIT, 16'd1);
        add_beat(KIND_FRAME, 32'd1750, '1, 32'd7, '1, 32'd3, 16'd1, 1'b0, NO_STATS);
        add_setting(CFG_WIN_LEN, 16'hFFFF);
        add_setting(CFG_FRAME_LIMIT, 16'd4095);
        add_beat(KIND_RESTART, 32'hFFFF_FFF0, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0,
                 1'b0, NO_STATS);
        add_beat(KIND_FRAME, 32'h0000_0010, 32'd16667, 32'd9000, 32'd7667, 32'd307200,
                 16'd2, 1'b0, NO_STATS);
        add_beat(KIND_FRAME, 32'h0000_0100, 32'd33333, 32'd20001, 32'd13332, 32'd1,
                 16'd5, 1'b0, NO_STATS);
        add_beat(KIND_TICK, 32'h0001_0000, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, NO_STATS);
        add_beat(KIND_TICK, 32'h0001_0001, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0, 1'b0, NO_STATS);
        add_beat(KIND_UNUSED, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 16'd0,
                 1'b0, NO_STATS);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            if (directed_steps[i].op == STEP_REGISTER) begin
                set_register(directed_steps[i].reg_idx, directed_steps[i].reg_val);
            end else begin
                drive_beat(directed_steps[i].beat, directed_steps[i].typed,
                           directed_steps[i].want);
            end
        end

        now_track = 32'hFFFF_0000;
        run_phase(16'd1000, 16'd64, 300);
        run_phase(16'd1, 16'd1, 200);
        run_phase(16'hFFFF, 16'd4095, 250);
        run_phase(16'd0, 16'd0, 150);
        run_phase(16'($urandom_range(1, 300)), 16'($urandom_range(1, 40)), 250);
        run_phase(16'($urandom_range(1, 300)), 16'($urandom_range(1, 40)), 250);
        run_phase(16'd20, 16'd5, 250);
        run_phase(16'd5000, 16'd4095, 200);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failed) begin
            $display("status: fail");
        end else begin
            $display("status: pass");
        end
        $finish;
    end

endmodule
